/* hw/rtl/mfre_pkg.sv */
package mfre_pkg;

	// frame geometry
	localparam int FRAME_WIDTH  = 128;
	localparam int FRAME_HEIGHT = 64;
	localparam int STORE_BYTES  = 1024;
	localparam int ADDR_W       = 10;
	localparam int COL_W        = 7;
	localparam int PAGE_W       = 3;
	localparam int ROW_W        = 6;
	localparam int CW           = 10;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	typedef logic signed [CW-1:0] coord_t;

	typedef enum logic [2:0] {
		CMD_CLEAR      = 3'd0,
		CMD_PIXEL      = 3'd1,
		CMD_LINE       = 3'd2,
		CMD_RECT       = 3'd3,
		CMD_FILLRECT   = 3'd4,
		CMD_CIRCLE     = 3'd5,
		CMD_FILLCIRCLE = 3'd6,
		CMD_READ       = 3'd7
	} cmd_t;

	typedef enum logic [3:0] {
		CL_NONE,
		CL_CLEAR,
		CL_PIXEL,
		CL_LINE,
		CL_RECT,
		CL_FILLRECT,
		CL_CIRCLE,
		CL_FILLCIRCLE,
		CL_READ
	} class_t;

	typedef struct packed {
		logic [2:0] command;
		logic [6:0] x_start;
		logic [5:0] y_start;
		logic [6:0] x_end;
		logic [5:0] y_end;
		logic [7:0] rect_width;
		logic [6:0] rect_height;
		logic [5:0] radius;
		logic       ink;
		logic [9:0] byte_index;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       done_res;
	} result_t;

	typedef struct packed {
		class_t cls;
		item_t  item;
	} entry_t;

	// request from shape sequencer to frame store
	typedef enum logic [1:0] {
		OP_SPAN,
		OP_CLEAR,
		OP_READ,
		OP_DONE
	} op_t;

	typedef struct packed {
		op_t               op;
		coord_t            x;
		coord_t            ylo;
		coord_t            yhi;
		logic              ink;
		logic [ADDR_W-1:0] addr;
	} fb_req_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PIX,
		S_L1,
		S_L2,
		S_LRUN,
		S_RSET,
		S_RECT,
		S_REDGE,
		S_FRECT,
		S_CINIT,
		S_CSTEP,
		S_CEMIT,
		S_FIN,
		S_CLR,
		S_RD
	} seq_state_t;

	typedef enum logic [2:0] {
		FB_INIT,
		FB_IDLE,
		FB_SRD,
		FB_SWR,
		FB_CLR,
		FB_BRD
	} fb_state_t;

	// zero-extend an unsigned field into a signed coordinate
	function automatic coord_t zx(input logic [7:0] v);
		return $signed({2'b00, v});
	endfunction

endpackage

/* hw/rtl/mfre_front.sv */
module mfre_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mfre_pkg::item_t  item,
	output logic             full,
	output logic             head_valid,
	input  logic             head_ready,
	output mfre_pkg::entry_t head
);

	mfre_pkg::entry_t                 q_mem [mfre_pkg::QUEUE_DEPTH];
	logic [mfre_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [mfre_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [mfre_pkg::QPTR_W:0]        cnt_q;
	mfre_pkg::class_t                 cls;
	logic                             pop_ok;

	// classify the incoming command
	always_comb begin
		unique case (mfre_pkg::cmd_t'(item.command))
			mfre_pkg::CMD_CLEAR:      cls = mfre_pkg::CL_CLEAR;
			mfre_pkg::CMD_PIXEL:      cls = mfre_pkg::CL_PIXEL;
			mfre_pkg::CMD_LINE:       cls = mfre_pkg::CL_LINE;
			mfre_pkg::CMD_RECT:       cls = (item.rect_width == '0 || item.rect_height == '0) ?
				mfre_pkg::CL_NONE : mfre_pkg::CL_RECT;
			mfre_pkg::CMD_FILLRECT:   cls = (item.rect_width == '0 || item.rect_height == '0) ?
				mfre_pkg::CL_NONE : mfre_pkg::CL_FILLRECT;
			mfre_pkg::CMD_CIRCLE:     cls = mfre_pkg::CL_CIRCLE;
			mfre_pkg::CMD_FILLCIRCLE: cls = mfre_pkg::CL_FILLCIRCLE;
			default:                  cls = mfre_pkg::CL_READ;
		endcase
	end

	assign full       = (cnt_q == (mfre_pkg::QPTR_W+1)'(mfre_pkg::QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = q_mem[rd_ptr_q];
	assign pop_ok     = head_valid && head_ready;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= '{cls: cls, item: item};
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop_ok) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop_ok) cnt_q <= cnt_q + 1'b1;
			else if (!push && pop_ok) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

/* hw/rtl/mfre_seq.sv */
module mfre_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  mfre_pkg::entry_t  head,
	output logic              head_ready,
	output logic              req_valid,
	output mfre_pkg::fb_req_t req,
	input  logic              req_ready
);

	mfre_pkg::seq_state_t state_q, state_d;
	logic [2:0]           k_q;
	mfre_pkg::item_t      it_q;
	mfre_pkg::class_t     cls_q;

	// line registers
	logic                 steep_q, yneg_q;
	logic [6:0]           la_q, lb_q, lend_q, lbend_q, ldx_q, ldy_q;
	logic signed [8:0]    err_q;

	// rectangle column walk
	mfre_pkg::coord_t     i_q, iend_q;

	// circle registers
	logic [5:0]           cxi_q, cyi_q;
	logic signed [10:0]   f_q, ddx_q, ddy_q;

	mfre_pkg::coord_t     cx, cy, ux, uy, ye_r, xr;
	logic [6:0]           dx, dy, px, py;
	logic                 steep, swap, fill_c, fill_r, last_k;
	logic signed [8:0]    err_n;
	logic signed [10:0]   ddy_n, f1, ddx_n;

	assign cx     = mfre_pkg::zx({1'b0, it_q.x_start});
	assign cy     = mfre_pkg::zx({2'b00, it_q.y_start});
	assign ux     = mfre_pkg::zx({2'b00, cxi_q});
	assign uy     = mfre_pkg::zx({2'b00, cyi_q});
	assign ye_r   = cy + mfre_pkg::zx({1'b0, it_q.rect_height}) - mfre_pkg::coord_t'(1);
	assign xr     = cx + mfre_pkg::zx(it_q.rect_width) - mfre_pkg::coord_t'(1);
	assign fill_c = (cls_q == mfre_pkg::CL_FILLCIRCLE);
	assign fill_r = (cls_q == mfre_pkg::CL_FILLRECT);

	// line setup terms
	assign dx    = (it_q.x_start > it_q.x_end) ? it_q.x_start - it_q.x_end
		: it_q.x_end - it_q.x_start;
	assign dy    = {1'b0, (it_q.y_start > it_q.y_end) ? it_q.y_start - it_q.y_end
		: it_q.y_end - it_q.y_start};
	assign steep = dy > dx;
	assign swap  = la_q > lend_q;
	assign err_n = err_q - $signed({2'b00, ldy_q});
	assign px    = steep_q ? lb_q : la_q;
	assign py    = steep_q ? la_q : lb_q;

	// circle step terms
	assign ddy_n = (f_q >= 0) ? ddy_q + 11'sd2 : ddy_q;
	assign f1    = (f_q >= 0) ? f_q + ddy_n : f_q;
	assign ddx_n = ddx_q + 11'sd2;

	assign last_k = fill_c ? (k_q == 3'd3) : (k_q == 3'd7);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mfre_pkg::S_IDLE: begin
				if (head_valid) begin
					unique case (head.cls)
						mfre_pkg::CL_NONE:       state_d = mfre_pkg::S_FIN;
						mfre_pkg::CL_CLEAR:      state_d = mfre_pkg::S_CLR;
						mfre_pkg::CL_PIXEL:      state_d = mfre_pkg::S_PIX;
						mfre_pkg::CL_LINE:       state_d = mfre_pkg::S_L1;
						mfre_pkg::CL_RECT,
						mfre_pkg::CL_FILLRECT:   state_d = mfre_pkg::S_RSET;
						mfre_pkg::CL_CIRCLE,
						mfre_pkg::CL_FILLCIRCLE: state_d = mfre_pkg::S_CINIT;
						default:                 state_d = mfre_pkg::S_RD;
					endcase
				end
			end
			mfre_pkg::S_PIX:  if (req_ready) state_d = mfre_pkg::S_FIN;
			mfre_pkg::S_L1:   state_d = mfre_pkg::S_L2;
			mfre_pkg::S_L2:   state_d = mfre_pkg::S_LRUN;
			mfre_pkg::S_LRUN: if (req_ready && la_q == lend_q) state_d = mfre_pkg::S_FIN;
			mfre_pkg::S_RSET: begin
				if (cx < mfre_pkg::coord_t'(mfre_pkg::FRAME_WIDTH))
					state_d = fill_r ? mfre_pkg::S_FRECT : mfre_pkg::S_RECT;
				else
					state_d = fill_r ? mfre_pkg::S_FIN : mfre_pkg::S_REDGE;
			end
			mfre_pkg::S_RECT:
				if (req_ready && k_q[0] && i_q == iend_q) state_d = mfre_pkg::S_REDGE;
			mfre_pkg::S_REDGE: if (req_ready && k_q[0]) state_d = mfre_pkg::S_FIN;
			mfre_pkg::S_FRECT: if (req_ready && i_q == iend_q) state_d = mfre_pkg::S_FIN;
			mfre_pkg::S_CINIT:
				if (req_ready && (fill_c || k_q == 3'd3)) state_d = mfre_pkg::S_CSTEP;
			mfre_pkg::S_CSTEP:
				state_d = (cxi_q < cyi_q) ? mfre_pkg::S_CEMIT : mfre_pkg::S_FIN;
			mfre_pkg::S_CEMIT: if (req_ready && last_k) state_d = mfre_pkg::S_CSTEP;
			mfre_pkg::S_FIN, mfre_pkg::S_CLR, mfre_pkg::S_RD:
				if (req_ready) state_d = mfre_pkg::S_IDLE;
			default: state_d = mfre_pkg::S_IDLE;
		endcase
	end

	// requests toward the frame store
	always_comb begin
		req        = '0;
		req.op     = mfre_pkg::OP_SPAN;
		req.ink    = it_q.ink;
		req.addr   = it_q.byte_index;
		req_valid  = 1'b0;
		head_ready = (state_q == mfre_pkg::S_IDLE);
		unique case (state_q)
			mfre_pkg::S_PIX: begin
				req_valid = 1'b1;
				req.x = cx; req.ylo = cy; req.yhi = cy;
			end
			mfre_pkg::S_LRUN: begin
				req_valid = 1'b1;
				req.x   = mfre_pkg::zx({1'b0, px});
				req.ylo = mfre_pkg::zx({1'b0, py});
				req.yhi = mfre_pkg::zx({1'b0, py});
			end
			mfre_pkg::S_RECT: begin
				req_valid = 1'b1;
				req.x   = i_q;
				req.ylo = k_q[0] ? ye_r : cy;
				req.yhi = k_q[0] ? ye_r : cy;
			end
			mfre_pkg::S_REDGE: begin
				req_valid = 1'b1;
				req.x   = k_q[0] ? xr : cx;
				req.ylo = cy;
				req.yhi = ye_r;
			end
			mfre_pkg::S_FRECT: begin
				req_valid = 1'b1;
				req.x = i_q; req.ylo = cy; req.yhi = ye_r;
			end
			mfre_pkg::S_CINIT: begin
				req_valid = 1'b1;
				if (fill_c) begin
					req.x = cx; req.ylo = cy - uy; req.yhi = cy + uy;
				end else begin
					unique case (k_q[1:0])
						2'd0: begin req.x = cx; req.ylo = cy + uy; end
						2'd1: begin req.x = cx; req.ylo = cy - uy; end
						2'd2: begin req.x = cx + uy; req.ylo = cy; end
						default: begin req.x = cx - uy; req.ylo = cy; end
					endcase
					req.yhi = req.ylo;
				end
			end
			mfre_pkg::S_CEMIT: begin
				req_valid = 1'b1;
				if (fill_c) begin
					unique case (k_q[1:0])
						2'd0: begin req.x = cx + ux; req.ylo = cy - uy; req.yhi = cy + uy; end
						2'd1: begin req.x = cx - ux; req.ylo = cy - uy; req.yhi = cy + uy; end
						2'd2: begin req.x = cx + uy; req.ylo = cy - ux; req.yhi = cy + ux; end
						default: begin
							req.x = cx - uy; req.ylo = cy - ux; req.yhi = cy + ux;
						end
					endcase
				end else begin
					unique case (k_q)
						3'd0: begin req.x = cx + ux; req.ylo = cy + uy; end
						3'd1: begin req.x = cx - ux; req.ylo = cy + uy; end
						3'd2: begin req.x = cx + ux; req.ylo = cy - uy; end
						3'd3: begin req.x = cx - ux; req.ylo = cy - uy; end
						3'd4: begin req.x = cx + uy; req.ylo = cy + ux; end
						3'd5: begin req.x = cx - uy; req.ylo = cy + ux; end
						3'd6: begin req.x = cx + uy; req.ylo = cy - ux; end
						default: begin req.x = cx - uy; req.ylo = cy - ux; end
					endcase
					req.yhi = req.ylo;
				end
			end
			mfre_pkg::S_FIN: begin
				req_valid = 1'b1; req.op = mfre_pkg::OP_DONE;
			end
			mfre_pkg::S_CLR: begin
				req_valid = 1'b1; req.op = mfre_pkg::OP_CLEAR;
			end
			mfre_pkg::S_RD: begin
				req_valid = 1'b1; req.op = mfre_pkg::OP_READ;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mfre_pkg::S_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) k_q <= '0;
			else if (req_valid && req_ready) k_q <= k_q + 3'd1;
		end
	end

	// shape datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			mfre_pkg::S_IDLE: begin
				if (head_valid) begin
					it_q  <= head.item;
					cls_q <= head.cls;
					cxi_q <= '0;
					cyi_q <= head.item.radius;
					f_q   <= 11'sd1 - $signed({5'b0, head.item.radius});
					ddx_q <= 11'sd1;
					ddy_q <= -$signed({4'b0, head.item.radius, 1'b0});
				end
			end
			mfre_pkg::S_L1: begin
				steep_q <= steep;
				ldx_q   <= steep ? dy : dx;
				ldy_q   <= steep ? dx : dy;
				la_q    <= steep ? {1'b0, it_q.y_start} : it_q.x_start;
				lb_q    <= steep ? it_q.x_start : {1'b0, it_q.y_start};
				lend_q  <= steep ? {1'b0, it_q.y_end} : it_q.x_end;
				lbend_q <= steep ? it_q.x_end : {1'b0, it_q.y_end};
			end
			mfre_pkg::S_L2: begin
				if (swap) begin
					la_q    <= lend_q;
					lend_q  <= la_q;
					lb_q    <= lbend_q;
					lbend_q <= lb_q;
					yneg_q  <= !(lb_q > lbend_q);
				end else begin
					yneg_q  <= !(lbend_q > lb_q);
				end
				err_q <= $signed({3'b000, ldx_q[6:1]});
			end
			mfre_pkg::S_LRUN: begin
				if (req_ready) begin
					la_q <= la_q + 7'd1;
					if (err_n < 0) begin
						lb_q  <= yneg_q ? lb_q - 7'd1 : lb_q + 7'd1;
						err_q <= err_n + $signed({2'b00, ldx_q});
					end else begin
						err_q <= err_n;
					end
				end
			end
			mfre_pkg::S_RSET: begin
				i_q    <= cx;
				iend_q <= (xr > mfre_pkg::coord_t'(mfre_pkg::FRAME_WIDTH - 1)) ?
					mfre_pkg::coord_t'(mfre_pkg::FRAME_WIDTH - 1) : xr;
			end
			mfre_pkg::S_RECT: if (req_ready && k_q[0]) i_q <= i_q + mfre_pkg::coord_t'(1);
			mfre_pkg::S_FRECT: if (req_ready) i_q <= i_q + mfre_pkg::coord_t'(1);
			mfre_pkg::S_CSTEP: begin
				if (cxi_q < cyi_q) begin
					if (f_q >= 0) cyi_q <= cyi_q - 6'd1;
					ddy_q <= ddy_n;
					cxi_q <= cxi_q + 6'd1;
					ddx_q <= ddx_n;
					f_q   <= f1 + ddx_n;
				end
			end
			default: ;
		endcase
	end

endmodule

/* hw/rtl/mfre_fb.sv */
module mfre_fb (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  mfre_pkg::fb_req_t req,
	output logic              req_ready,
	output logic              init_busy,
	input  logic              pop,
	output logic              empty,
	output mfre_pkg::result_t result
);

	logic [7:0]                    mem [mfre_pkg::STORE_BYTES];
	mfre_pkg::fb_state_t           state_q, state_d;
	logic [mfre_pkg::ADDR_W-1:0]   cnt_q;
	logic [mfre_pkg::COL_W-1:0]    x_q;
	logic [mfre_pkg::PAGE_W-1:0]   pg_q;
	logic [mfre_pkg::ROW_W-1:0]    ylo_q, yhi_q;
	logic                          ink_q;
	logic [7:0]                    rdata_q;
	logic                          res_valid_q;
	mfre_pkg::result_t             res_q;

	mfre_pkg::coord_t              ylo_c, yhi_c;
	logic                          hit, take, rd_en, we, sweep_end;
	logic [mfre_pkg::ADDR_W-1:0]   rd_addr, wr_addr, span_addr;
	logic [7:0]                    wr_data, mask;
	logic [2:0]                    lo, hi;

	// clip the span to the frame
	assign ylo_c = (req.ylo < 0) ? '0 : req.ylo;
	assign yhi_c = (req.yhi > mfre_pkg::coord_t'(mfre_pkg::FRAME_HEIGHT - 1)) ?
		mfre_pkg::coord_t'(mfre_pkg::FRAME_HEIGHT - 1) : req.yhi;
	assign hit   = (req.x >= 0) && (req.x < mfre_pkg::coord_t'(mfre_pkg::FRAME_WIDTH))
		&& (ylo_c <= yhi_c);

	assign req_ready = (state_q == mfre_pkg::FB_IDLE)
		&& (req.op == mfre_pkg::OP_SPAN || !res_valid_q);
	assign take      = req_valid && req_ready;
	assign init_busy = (state_q == mfre_pkg::FB_INIT);
	assign sweep_end = (cnt_q == {mfre_pkg::ADDR_W{1'b1}});
	assign span_addr = {pg_q, x_q};

	// rows of the current page covered by the span
	assign lo   = (pg_q == ylo_q[5:3]) ? ylo_q[2:0] : 3'd0;
	assign hi   = (pg_q == yhi_q[5:3]) ? yhi_q[2:0] : 3'd7;
	assign mask = (8'hFF >> lo) & (8'hFF << (3'd7 - hi));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mfre_pkg::FB_INIT, mfre_pkg::FB_CLR:
				if (sweep_end) state_d = mfre_pkg::FB_IDLE;
			mfre_pkg::FB_IDLE: begin
				if (take) begin
					unique case (req.op)
						mfre_pkg::OP_SPAN:  state_d = hit ? mfre_pkg::FB_SRD : mfre_pkg::FB_IDLE;
						mfre_pkg::OP_CLEAR: state_d = mfre_pkg::FB_CLR;
						mfre_pkg::OP_READ:  state_d = mfre_pkg::FB_BRD;
						default:            state_d = mfre_pkg::FB_IDLE;
					endcase
				end
			end
			mfre_pkg::FB_SRD: state_d = mfre_pkg::FB_SWR;
			mfre_pkg::FB_SWR:
				state_d = (pg_q == yhi_q[5:3]) ? mfre_pkg::FB_IDLE : mfre_pkg::FB_SRD;
			default: state_d = mfre_pkg::FB_IDLE;
		endcase
	end

	// memory port controls
	always_comb begin
		rd_en   = (state_q == mfre_pkg::FB_SRD)
			|| (take && req.op == mfre_pkg::OP_READ);
		rd_addr = (state_q == mfre_pkg::FB_SRD) ? span_addr : req.addr;
		we      = 1'b0;
		wr_addr = cnt_q;
		wr_data = '0;
		unique case (state_q)
			mfre_pkg::FB_INIT, mfre_pkg::FB_CLR: we = 1'b1;
			mfre_pkg::FB_SWR: begin
				we      = 1'b1;
				wr_addr = span_addr;
				wr_data = ink_q ? (rdata_q | mask) : (rdata_q & ~mask);
			end
			default: ;
		endcase
	end

	// frame store
	always_ff @(posedge clk) begin
		if (we) mem[wr_addr] <= wr_data;
		if (rd_en) rdata_q <= mem[rd_addr];
	end

	// span registers
	always_ff @(posedge clk) begin
		if (state_q == mfre_pkg::FB_IDLE && take && req.op == mfre_pkg::OP_SPAN) begin
			x_q   <= req.x[mfre_pkg::COL_W-1:0];
			ylo_q <= ylo_c[mfre_pkg::ROW_W-1:0];
			yhi_q <= yhi_c[mfre_pkg::ROW_W-1:0];
			pg_q  <= ylo_c[mfre_pkg::ROW_W-1:3];
			ink_q <= req.ink;
		end else if (state_q == mfre_pkg::FB_SWR) begin
			pg_q <= pg_q + 1'b1;
		end
	end

	// control and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mfre_pkg::FB_INIT;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == mfre_pkg::FB_INIT || state_q == mfre_pkg::FB_CLR)
				cnt_q <= cnt_q + 1'b1;
			if (pop && res_valid_q) res_valid_q <= 1'b0;
			if ((take && req.op == mfre_pkg::OP_DONE) || state_q == mfre_pkg::FB_BRD
				|| (state_q == mfre_pkg::FB_CLR && sweep_end))
				res_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mfre_pkg::FB_BRD) res_q <= '{read_data: rdata_q, done_res: 1'b1};
		else if (!res_valid_q) res_q <= '{read_data: 8'd0, done_res: 1'b1};
	end

	assign empty  = !res_valid_q;
	assign result = res_q;

endmodule

/* hw/rtl/mono_framebuffer_raster_engine_top.sv */
// channel   | direction | handshake        | payload
// ----------+-----------+------------------+--------------------------
// command   | in        | push / full      | item   (mfre_pkg::item_t)
// result    | out       | pop / empty      | result (mfre_pkg::result_t)
//
// Commands queue four deep ahead of the shape sequencer, one command worked at a time.
// Each frame store page touched by a span is read and then written back (read, then write of
// the byte) once the span is accepted; a span or point off the frame is accepted and dropped
// without touching the store. Clear sweeps every byte of the store, read byte fetches one
// byte into the result register, and a fill walks the rectangle column by column.
// After reset a clearing pass runs over the store with full held high.
// A waiting result stalls only the next clear, read or command end, not drawing.
module mono_framebuffer_raster_engine_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  mfre_pkg::item_t   item,
	input  logic              pop,
	output logic              empty,
	output mfre_pkg::result_t result
);

	logic              front_full, head_valid, head_ready;
	logic              req_valid, req_ready, init_busy;
	mfre_pkg::entry_t  head;
	mfre_pkg::fb_req_t req;

	assign full = front_full || init_busy;

	mfre_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push && !full),
		.item       (item),
		.full       (front_full),
		.head_valid (head_valid),
		.head_ready (head_ready),
		.head       (head)
	);

	mfre_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.head_ready (head_ready),
		.req_valid  (req_valid),
		.req        (req),
		.req_ready  (req_ready)
	);

	mfre_fb u_fb (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_ready (req_ready),
		.init_busy (init_busy),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

	// no command enters during the clearing pass
	a_init_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> full)
		else $error("command accepted during clearing pass");

	// a full queue always offers a head entry
	a_queue_head: assert property (@(posedge clk) disable iff (!arst_n)
		front_full |-> head_valid)
		else $error("queue full without head entry");

	// a result-producing request only lands in an empty result register
	a_result_free: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && req.op != mfre_pkg::OP_SPAN) |-> empty)
		else $error("result register overwritten");

endmodule
